// File: design/zbsr_pkg.sv
// ----------------------------------------------------------------------------
// zbsr_pkg
// Shared types and constants of the depth-tested sprite rasterizer: command
// codes, camera constants, glyph codes, divider interface and sequencer states.
// ----------------------------------------------------------------------------
package zbsr_pkg;

    // command codes
    localparam logic [2:0] MODE_CLEAR  = 3'd0;
    localparam logic [2:0] MODE_GRID   = 3'd1;
    localparam logic [2:0] MODE_SPHERE = 3'd2;
    localparam logic [2:0] MODE_BOX    = 3'd3;
    localparam logic [2:0] MODE_READ   = 3'd4;

    // divider operand widths
    localparam int NUM_W   = 48;
    localparam int DEN_W   = 40;
    localparam int DEPTH_W = 24;
    localparam int FRAC_W  = 12;

    localparam logic [DEPTH_W-1:0] DEPTH_MAX = 24'hFFFFFF;

    // camera: pitch cos/sin in Q12, position in Q12
    localparam logic signed [12:0] COS_Q12   = 13'sd3711;
    localparam logic signed [12:0] SIN_Q12   = 13'sd1729;
    localparam logic signed [24:0] CAM_Y_Q12 = 25'sd49152;
    localparam logic signed [24:0] CAM_Z_Q12 = -25'sd90112;
    localparam logic signed [DEN_W-1:0] NEAR_LIM = 40'sd8388608;

    // glyph codes
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_BAR   = 8'h7C;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_DOT   = 8'h2E;

    // grid floor walk
    localparam logic [3:0] GRID_LAST = 4'd10;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [NUM_W-1:0] quo;
        logic             rem_nz;
    } div_rsp_t;

    typedef enum logic [4:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLEAR,
        ST_PROJ_A,
        ST_PROJ_B,
        ST_PROJ_C,
        ST_PROJ_D,
        ST_SX_WAIT,
        ST_SY_GO,
        ST_SY_WAIT,
        ST_CHECK,
        ST_FA_GO,
        ST_FA_WAIT,
        ST_FB_GO,
        ST_FB_WAIT,
        ST_SETUP,
        ST_CELL_RD,
        ST_CELL_WR,
        ST_READ_WAIT,
        ST_DONE
    } state_t;

    // grid coordinate -20 + 4k in Q11.12
    function automatic logic signed [23:0] grid_coord(input logic [3:0] k);
        logic signed [7:0] v;
        v = $signed({2'b00, k, 2'b00}) - 8'sd20;
        return {{4{v[7]}}, v, 12'b0};
    endfunction

endpackage

// File: design/zbsr_ram.sv
// ----------------------------------------------------------------------------
// zbsr_ram
// Generic single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module zbsr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2800
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

// File: design/zbsr_div.sv
// ----------------------------------------------------------------------------
// zbsr_div
// Restoring unsigned divider, one quotient bit per cycle. Returns the quotient
// and whether the remainder is nonzero, for floor correction upstream.
// ----------------------------------------------------------------------------
module zbsr_div (
    input  logic                aclk,
    input  logic                aresetn,
    input  zbsr_pkg::div_req_t  req,
    output zbsr_pkg::div_rsp_t  rsp
);
    import zbsr_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DEN_W:0]   shifted;
    logic [DEN_W:0]   trial;

    // one restoring step per cycle
    always_comb begin
        shifted   = {rem_reg, quo_reg[NUM_W-1]};
        trial     = shifted - {1'b0, den_reg};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            quo_next  = req.num;
            rem_next  = '0;
            den_next  = req.den;
            cnt_next  = CNT_W'(NUM_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!trial[DEN_W]) begin
                rem_next = trial[DEN_W-1:0];
                quo_next = {quo_reg[NUM_W-2:0], 1'b1};
            end else begin
                rem_next = shifted[DEN_W-1:0];
                quo_next = {quo_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // operands
    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign rsp.busy   = busy_reg;
    assign rsp.done   = done_reg;
    assign rsp.quo    = quo_reg;
    assign rsp.rem_nz = |rem_reg;

endmodule

// File: design/z_buffered_sprite_rasterizer_core.sv
// ----------------------------------------------------------------------------
// z_buffered_sprite_rasterizer_core
// Depth-tested character rasterizer. Glyph and depth of every cell share one
// frame memory word; draws walk the covered cells with read-modify-write.
//
//   channel  | direction | ports
//   ---------+-----------+-----------------------------------------------
//   s_       | in        | s_valid/s_ready, mode, pos, size, glyph, cell
//   m_       | out       | m_valid/m_ready, visible, glyph_out, depth_out
//
// timing: set by the 48-step serial divider and the memory port; sphere and box
//   run projection and footprint divides, then a read-modify-write per covered
//   interior cell and a skip per uncovered cell of a sphere's bounding box; the grid
//   floor runs the projection divides per point and writes the plotted ones
// reset: a clearing pass over all FRAME_WIDTH*FRAME_HEIGHT cells, s_ready low
// stalls: one result beat is held in the output register while the next
//   command is taken; a command finishes only once that beat has left
// ----------------------------------------------------------------------------
module z_buffered_sprite_rasterizer_core #(
    parameter int FRAME_WIDTH  = 80,
    parameter int FRAME_HEIGHT = 35
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [2:0]         s_mode,
    input  logic signed [23:0] s_pos_x,
    input  logic signed [23:0] s_pos_y,
    input  logic signed [23:0] s_pos_z,
    input  logic [19:0]        s_size_x,
    input  logic [19:0]        s_size_y,
    input  logic [7:0]         s_glyph,
    input  logic [11:0]        s_cell_index,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_visible,
    output logic [7:0]         m_glyph_out,
    output logic [23:0]        m_depth_out
);
    import zbsr_pkg::*;

    localparam int CELLS    = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int AW       = $clog2(CELLS);
    localparam int CW       = $clog2(FRAME_WIDTH);
    localparam int RW       = $clog2(FRAME_HEIGHT);
    localparam int FOOT_CAP = FRAME_WIDTH + 2 * FRAME_HEIGHT;
    localparam int FW       = $clog2(FOOT_CAP + 1);
    localparam int SW       = FW + 2;
    localparam int SQ_W     = 2 * FW + 2;
    localparam int WIDE_W   = NUM_W + 2;
    localparam int MEM_W    = 8 + DEPTH_W;

    state_t state_reg, state_next;

    // command payload
    logic [2:0]         mode_reg;
    logic signed [23:0] px_reg, py_reg, pz_reg;
    logic [19:0]        sizex_reg, sizey_reg;
    logic [7:0]         glyph_reg;

    // projection pipeline
    logic [3:0]               gi_reg, gj_reg;
    logic signed [23:0]       projx_reg;
    logic signed [24:0]       ry_reg, rz_reg;
    logic signed [37:0]       pyc_reg, pzs_reg, pys_reg, pzc_reg;
    logic signed [DEN_W-1:0]  roty_reg, rotz_reg;
    logic [DEPTH_W-1:0]       d_reg;
    logic [CW-1:0]            sx_reg;
    logic [RW-1:0]            sy_reg;
    logic                     sxok_reg, syok_reg;
    logic [FW-1:0]            foota_reg, footb_reg;

    // cell walk
    logic [CW-1:0]   x_reg, xlo_reg, xhi_reg;
    logic [RW-1:0]   y_reg, yhi_reg;
    logic [SQ_W-1:0] rsq_reg;

    // clearing sweep
    logic [AW-1:0] clr_addr_reg;
    logic [CW-1:0] clr_col_reg;
    logic [RW-1:0] clr_row_reg;

    // result
    logic        res_vis_reg;
    logic [7:0]  res_glyph_reg;
    logic [23:0] res_depth_reg;
    logic        m_valid_reg, m_visible_reg;
    logic [7:0]  m_glyph_reg;
    logic [23:0] m_depth_reg;

    // combinational
    logic             is_grid, is_sphere, is_box;
    logic             accept, rd_in_range, clr_last, near, walk_last, grid_last, out_free;
    logic             ram_we;
    logic [AW-1:0]    ram_addr, walk_addr, rd_addr;
    logic [MEM_W-1:0] ram_wdata, ram_rdata;
    logic [7:0]       clr_glyph;
    div_req_t         div_req;
    div_rsp_t         div_rsp;
    logic [23:0]      pxa;
    logic [DEN_W-1:0] rya;
    logic [NUM_W-1:0] pxa_w, rya_w, num_sx, num_sy, num_fa, num_fb;
    logic             div_neg;
    logic signed [WIDE_W-1:0] qe, qs, pos_wide;
    logic             pos_ok;
    logic [FW-1:0]    foot_sat;
    logic signed [SW-1:0] sxe, sye, ext_x, ext_y, lo_x, hi_x, lo_y, hi_y, dx, dy;
    logic [CW-1:0]    clip_xlo, clip_xhi;
    logic [RW-1:0]    clip_ylo, clip_yhi;
    logic [SW-1:0]    dxa, dya;
    logic [SQ_W-1:0]  lhs;
    logic             in_ellipse, depth_win;
    logic signed [23:0] gz;

    zbsr_ram #(
        .WIDTH(MEM_W),
        .DEPTH(CELLS)
    ) u_frame (
        .aclk (aclk),
        .we   (ram_we),
        .addr (ram_addr),
        .wdata(ram_wdata),
        .rdata(ram_rdata)
    );

    zbsr_div u_div (
        .aclk   (aclk),
        .aresetn(aresetn),
        .req    (div_req),
        .rsp    (div_rsp)
    );

    // command decode and status
    always_comb begin
        is_grid     = (mode_reg == MODE_GRID);
        is_sphere   = (mode_reg == MODE_SPHERE);
        is_box      = (mode_reg == MODE_BOX);
        accept      = s_valid && (state_reg == ST_IDLE);
        rd_in_range = 32'(s_cell_index) < 32'(CELLS);
        rd_addr     = AW'(s_cell_index);
        clr_last    = (clr_addr_reg == AW'(CELLS - 1));
        near        = (rotz_reg <= NEAR_LIM);
        walk_last   = (x_reg == xhi_reg) && (y_reg == yhi_reg);
        grid_last   = (gi_reg == GRID_LAST) && (gj_reg == GRID_LAST);
        out_free    = !m_valid_reg || m_ready;
        walk_addr   = AW'(32'(y_reg) * 32'(FRAME_WIDTH) + 32'(x_reg));
        depth_win   = d_reg < ram_rdata[DEPTH_W-1:0];
        gz          = grid_coord(gj_reg);
    end

    // border glyph of the swept cell
    always_comb begin
        logic top_bot, side;
        top_bot = (clr_row_reg == '0) || (clr_row_reg == RW'(FRAME_HEIGHT - 1));
        side    = (clr_col_reg == '0) || (clr_col_reg == CW'(FRAME_WIDTH - 1));
        if (top_bot && side) begin
            clr_glyph = CH_PLUS;
        end else if (top_bot) begin
            clr_glyph = CH_EQ;
        end else if (side) begin
            clr_glyph = CH_BAR;
        end else begin
            clr_glyph = CH_SPACE;
        end
    end

    // divider numerators
    always_comb begin
        pxa    = projx_reg[23] ? 24'(-projx_reg) : 24'(projx_reg);
        rya    = roty_reg[DEN_W-1] ? DEN_W'(-roty_reg) : DEN_W'(roty_reg);
        pxa_w  = NUM_W'(pxa);
        rya_w  = NUM_W'(rya);
        num_sx = (pxa_w << 18) + (pxa_w << 14) + (pxa_w << 13);
        num_sy = (rya_w << 5) + (rya_w << 1) + rya_w;
        num_fa = is_sphere ? NUM_W'(sizex_reg) * NUM_W'(60) : NUM_W'(sizex_reg) * NUM_W'(70);
        num_fb = NUM_W'(sizey_reg) * NUM_W'(35);
    end

    // floor-signed quotient and screen range test
    always_comb begin
        div_neg = (state_reg == ST_SX_WAIT) ? projx_reg[23]
                                            : (!roty_reg[DEN_W-1] && (roty_reg != '0));
        qe = signed'(WIDE_W'(div_rsp.quo));
        qs = div_neg ? (-qe - WIDE_W'(div_rsp.rem_nz)) : qe;
        if (state_reg == ST_SX_WAIT) begin
            pos_wide = qs + WIDE_W'(FRAME_WIDTH / 2);
            pos_ok   = (pos_wide > 0) && (pos_wide < WIDE_W'(FRAME_WIDTH - 1));
        end else begin
            pos_wide = qs + WIDE_W'(FRAME_HEIGHT / 2);
            pos_ok   = (pos_wide > 0) && (pos_wide < WIDE_W'(FRAME_HEIGHT - 1));
        end
        if (div_rsp.quo > NUM_W'(FOOT_CAP)) begin
            foot_sat = FW'(FOOT_CAP);
        end else if (div_rsp.quo == '0) begin
            foot_sat = FW'(1);
        end else begin
            foot_sat = FW'(div_rsp.quo);
        end
    end

    // footprint clipped to the frame interior
    always_comb begin
        sxe   = signed'(SW'(sx_reg));
        sye   = signed'(SW'(sy_reg));
        ext_x = signed'(SW'(foota_reg));
        ext_y = signed'(SW'(footb_reg));
        lo_x  = sxe - ext_x;
        hi_x  = sxe + ext_x;
        lo_y  = sye - ext_y;
        hi_y  = sye + ext_y;
        clip_xlo = (lo_x < SW'(1)) ? CW'(1) : CW'(lo_x);
        clip_xhi = (hi_x > SW'(FRAME_WIDTH - 2)) ? CW'(FRAME_WIDTH - 2) : CW'(hi_x);
        clip_ylo = (lo_y < SW'(1)) ? RW'(1) : RW'(lo_y);
        clip_yhi = (hi_y > SW'(FRAME_HEIGHT - 2)) ? RW'(FRAME_HEIGHT - 2) : RW'(hi_y);
    end

    // sphere coverage test
    always_comb begin
        dx  = signed'(SW'(x_reg)) - sxe;
        dy  = signed'(SW'(y_reg)) - sye;
        dxa = dx[SW-1] ? SW'(-dx) : SW'(dx);
        dya = dy[SW-1] ? SW'(-dy) : SW'(dy);
        lhs = SQ_W'(dxa) * SQ_W'(dxa) + ((SQ_W'(dya) * SQ_W'(dya)) << 2);
        in_ellipse = (lhs <= rsq_reg);
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT: begin
                if (clr_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_valid) begin
                    case (s_mode)
                        MODE_CLEAR: state_next = ST_CLEAR;
                        MODE_GRID, MODE_SPHERE, MODE_BOX: state_next = ST_PROJ_A;
                        MODE_READ: state_next = rd_in_range ? ST_READ_WAIT : ST_DONE;
                        default: state_next = ST_DONE;
                    endcase
                end
            end
            ST_CLEAR: begin
                if (clr_last) state_next = ST_DONE;
            end
            ST_PROJ_A: state_next = ST_PROJ_B;
            ST_PROJ_B: state_next = ST_PROJ_C;
            ST_PROJ_C: state_next = ST_PROJ_D;
            ST_PROJ_D: begin
                if (!near) begin
                    state_next = ST_SX_WAIT;
                end else if (is_grid && !grid_last) begin
                    state_next = ST_PROJ_A;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_SX_WAIT: begin
                if (div_rsp.done) state_next = ST_SY_GO;
            end
            ST_SY_GO: state_next = ST_SY_WAIT;
            ST_SY_WAIT: begin
                if (div_rsp.done) state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if (!(sxok_reg && syok_reg)) begin
                    state_next = (is_grid && !grid_last) ? ST_PROJ_A : ST_DONE;
                end else if (is_grid) begin
                    state_next = ST_SETUP;
                end else begin
                    state_next = ST_FA_GO;
                end
            end
            ST_FA_GO: state_next = ST_FA_WAIT;
            ST_FA_WAIT: begin
                if (div_rsp.done) state_next = is_box ? ST_FB_GO : ST_SETUP;
            end
            ST_FB_GO: state_next = ST_FB_WAIT;
            ST_FB_WAIT: begin
                if (div_rsp.done) state_next = ST_SETUP;
            end
            ST_SETUP: state_next = ST_CELL_RD;
            ST_CELL_RD: begin
                if (is_sphere && !in_ellipse) begin
                    if (walk_last) begin
                        state_next = ST_DONE;
                    end
                end else begin
                    state_next = ST_CELL_WR;
                end
            end
            ST_CELL_WR: begin
                if (!walk_last) begin
                    state_next = ST_CELL_RD;
                end else if (is_grid && !grid_last) begin
                    state_next = ST_PROJ_A;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_READ_WAIT: state_next = ST_DONE;
            ST_DONE: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_INIT;
        endcase
    end

    // outputs: handshake, memory port, divider request
    always_comb begin
        s_ready     = (state_reg == ST_IDLE);
        ram_we      = 1'b0;
        ram_addr    = walk_addr;
        ram_wdata   = {is_grid ? CH_DOT : glyph_reg, d_reg};
        div_req     = '0;
        div_req.den = DEN_W'(rotz_reg);
        case (state_reg)
            ST_INIT, ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_addr  = clr_addr_reg;
                ram_wdata = {clr_glyph, DEPTH_MAX};
            end
            ST_IDLE: begin
                ram_addr = rd_addr;
            end
            ST_PROJ_D: begin
                div_req.start = !near;
                div_req.num   = num_sx;
            end
            ST_SY_GO: begin
                div_req.start = 1'b1;
                div_req.num   = num_sy;
            end
            ST_FA_GO: begin
                div_req.start = 1'b1;
                div_req.num   = num_fa;
                div_req.den   = DEN_W'(d_reg);
            end
            ST_FB_GO: begin
                div_req.start = 1'b1;
                div_req.num   = num_fb;
                div_req.den   = DEN_W'(d_reg);
            end
            ST_CELL_WR: begin
                ram_we = depth_win;
            end
            default: begin
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_INIT;
            clr_addr_reg <= '0;
            clr_col_reg  <= '0;
            clr_row_reg  <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (accept) begin
                clr_addr_reg <= '0;
                clr_col_reg  <= '0;
                clr_row_reg  <= '0;
            end else if (state_reg == ST_INIT || state_reg == ST_CLEAR) begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
                if (clr_col_reg == CW'(FRAME_WIDTH - 1)) begin
                    clr_col_reg <= '0;
                    clr_row_reg <= clr_row_reg + RW'(1);
                end else begin
                    clr_col_reg <= clr_col_reg + CW'(1);
                end
            end
            if (state_reg == ST_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        // command capture
        if (accept) begin
            mode_reg      <= s_mode;
            px_reg        <= s_pos_x;
            py_reg        <= s_pos_y;
            pz_reg        <= s_pos_z;
            sizex_reg     <= s_size_x;
            sizey_reg     <= s_size_y;
            glyph_reg     <= s_glyph;
            gi_reg        <= '0;
            gj_reg        <= '0;
            res_vis_reg   <= 1'b0;
            res_glyph_reg <= '0;
            res_depth_reg <= '0;
        end
        // next grid point
        if (state_next == ST_PROJ_A && state_reg != ST_IDLE) begin
            if (gj_reg == GRID_LAST) begin
                gj_reg <= '0;
                gi_reg <= gi_reg + 4'd1;
            end else begin
                gj_reg <= gj_reg + 4'd1;
            end
        end
        // camera transform
        if (state_reg == ST_PROJ_A) begin
            projx_reg <= is_grid ? grid_coord(gi_reg) : px_reg;
            ry_reg    <= 25'(py_reg) - CAM_Y_Q12;
            rz_reg    <= 25'(is_grid ? gz : pz_reg) - CAM_Z_Q12;
        end
        if (state_reg == ST_PROJ_B) begin
            pyc_reg <= ry_reg * COS_Q12;
            pzs_reg <= rz_reg * SIN_Q12;
            pys_reg <= ry_reg * SIN_Q12;
            pzc_reg <= rz_reg * COS_Q12;
        end
        if (state_reg == ST_PROJ_C) begin
            roty_reg <= DEN_W'(pyc_reg) - DEN_W'(pzs_reg);
            rotz_reg <= DEN_W'(pys_reg) + DEN_W'(pzc_reg);
        end
        if (state_reg == ST_PROJ_D) begin
            d_reg <= (|rotz_reg[DEN_W-1:DEPTH_W+FRAC_W]) ? DEPTH_MAX
                                                          : rotz_reg[DEPTH_W+FRAC_W-1:FRAC_W];
        end
        // screen position
        if (state_reg == ST_SX_WAIT && div_rsp.done) begin
            sxok_reg <= pos_ok;
            sx_reg   <= CW'(pos_wide);
        end
        if (state_reg == ST_SY_WAIT && div_rsp.done) begin
            syok_reg <= pos_ok;
            sy_reg   <= RW'(pos_wide);
        end
        if (state_reg == ST_CHECK) begin
            res_vis_reg <= sxok_reg && syok_reg && !is_grid;
            foota_reg   <= '0;
            footb_reg   <= '0;
        end
        // footprints
        if (state_reg == ST_FA_WAIT && div_rsp.done) begin
            foota_reg <= foot_sat;
            footb_reg <= foot_sat >> 1;
        end
        if (state_reg == ST_FB_WAIT && div_rsp.done) begin
            footb_reg <= foot_sat;
        end
        // walk setup
        if (state_reg == ST_SETUP) begin
            xlo_reg <= clip_xlo;
            xhi_reg <= clip_xhi;
            yhi_reg <= clip_yhi;
            x_reg   <= clip_xlo;
            y_reg   <= clip_ylo;
            rsq_reg <= SQ_W'(foota_reg) * SQ_W'(foota_reg) + SQ_W'(1);
        end
        // walk advance
        if ((state_reg == ST_CELL_RD && is_sphere && !in_ellipse) || state_reg == ST_CELL_WR) begin
            if (x_reg == xhi_reg) begin
                x_reg <= xlo_reg;
                y_reg <= y_reg + RW'(1);
            end else begin
                x_reg <= x_reg + CW'(1);
            end
        end
        // read cell
        if (state_reg == ST_READ_WAIT) begin
            res_glyph_reg <= ram_rdata[MEM_W-1:DEPTH_W];
            res_depth_reg <= ram_rdata[DEPTH_W-1:0];
        end
        // output beat
        if (state_reg == ST_DONE && out_free) begin
            m_visible_reg <= res_vis_reg;
            m_glyph_reg   <= res_glyph_reg;
            m_depth_reg   <= res_depth_reg;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_visible   = m_visible_reg;
    assign m_glyph_out = m_glyph_reg;
    assign m_depth_out = m_depth_reg;

    // frame memory is written only by the sweep or a depth-test win
    a_write_src: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == ST_INIT || state_reg == ST_CLEAR || state_reg == ST_CELL_WR))
        else $error("frame write outside sweep or depth update");

    // a draw write always carries a strictly nearer depth
    a_depth_win: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CELL_WR && ram_we) |-> (d_reg < ram_rdata[DEPTH_W-1:0]))
        else $error("draw write without nearer depth");

    // divider is started only while idle
    a_div_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        div_req.start |-> !div_rsp.busy)
        else $error("divider restarted while busy");

    // walked cells stay inside the border
    a_walk_inside: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CELL_RD) |-> (x_reg >= CW'(1) && x_reg <= CW'(FRAME_WIDTH - 2)
                                      && y_reg >= RW'(1) && y_reg <= RW'(FRAME_HEIGHT - 2)))
        else $error("walk left the frame interior");

    // only sphere and box report visibility
    a_vis_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && res_vis_reg) |-> (mode_reg == MODE_SPHERE || mode_reg == MODE_BOX))
        else $error("visible flag on a non-draw command");

endmodule

// File: tb/z_buffered_sprite_rasterizer_core_tb.sv
// ----------------------------------------------------------------------------
// z_buffered_sprite_rasterizer_core_tb
// Self-checking bench for the depth-tested sprite rasterizer. A shadow frame
// (glyph and depth per cell) is updated for every accepted command and each
// result beat is compared against the oldest predicted beat. Stimulus: a
// directed opening, then mostly well-formed draws and reads with some noise,
// random stalls on both channels, one long output hold-off and one drain.
// ----------------------------------------------------------------------------
module z_buffered_sprite_rasterizer_core_tb;
    import zbsr_pkg::*;

    localparam int W          = 80;
    localparam int H          = 35;
    localparam int CELLS      = W * H;
    localparam int FOOT_LIMIT = W + 2 * H;
    localparam int IDLE_LIMIT = 400000;
    localparam int N_RANDOM   = 1880;

    typedef struct {
        logic [2:0]         mode;
        logic signed [23:0] px, py, pz;
        logic [19:0]        sx, sy;
        logic [7:0]         glyph;
        logic [11:0]        cell_idx;
    } cmd_t;

    typedef struct {
        logic        visible;
        logic [7:0]  glyph;
        logic [23:0] depth;
    } beat_t;

    // shadow of the frame memory plus the queue of predicted result beats
    class frame_shadow;
        bit [7:0]  glyph_mem [CELLS];
        bit [23:0] depth_mem [CELLS];
        beat_t     awaited [$];
        int        errors;

        function new();
            errors = 0;
            wipe();
        endfunction

        function void wipe();
            for (int i = 0; i < CELLS; i++) begin
                glyph_mem[i] = CH_SPACE;
                depth_mem[i] = DEPTH_MAX;
            end
            for (int x = 0; x < W; x++) begin
                glyph_mem[x] = CH_EQ;
                glyph_mem[(H - 1) * W + x] = CH_EQ;
            end
            for (int y = 0; y < H; y++) begin
                glyph_mem[y * W] = CH_BAR;
                glyph_mem[y * W + W - 1] = CH_BAR;
            end
            glyph_mem[0] = CH_PLUS;
            glyph_mem[W - 1] = CH_PLUS;
            glyph_mem[(H - 1) * W] = CH_PLUS;
            glyph_mem[(H - 1) * W + W - 1] = CH_PLUS;
        endfunction

        function longint floor_quo(longint a, longint b);
            longint q;
            q = a / b;
            if ((a % b) != 0 && a < 0) q--;
            return q;
        endfunction

        // perspective projection; returns on-screen flag
        function bit project(longint px, longint py, longint pz,
                             output longint scr_x, output longint scr_y,
                             output bit [23:0] dep);
            longint ry, rz, rot_y, rot_z, d;
            ry = py - 49152;
            rz = pz + 90112;
            rot_y = ry * 3711 - rz * 1729;
            rot_z = ry * 1729 + rz * 3711;
            scr_x = 0;
            scr_y = 0;
            dep = 0;
            if (rot_z <= 64'sd8388608) return 0;
            d = rot_z / 4096;
            dep = (d > 64'sh FFFFFF) ? DEPTH_MAX : d[23:0];
            scr_x = W / 2 + floor_quo(px * 70 * 4096, rot_z);
            scr_y = H / 2 + floor_quo(-rot_y * 35, rot_z);
            return scr_x > 0 && scr_x < W - 1 && scr_y > 0 && scr_y < H - 1;
        endfunction

        function void plot(longint x, longint y, bit [23:0] dep, bit [7:0] ch);
            longint idx;
            if (x <= 0 || x >= W - 1 || y <= 0 || y >= H - 1) return;
            idx = y * W + x;
            if (dep < depth_mem[idx]) begin
                depth_mem[idx] = dep;
                glyph_mem[idx] = ch;
            end
        endfunction

        function longint foot(longint size, longint scale, bit [23:0] dep);
            longint f;
            f = size * scale / longint'(dep);
            if (f < 1) f = 1;
            if (f > FOOT_LIMIT) f = FOOT_LIMIT;
            return f;
        endfunction

        // apply one accepted command and queue its predicted beat
        function void take_command(cmd_t c);
            beat_t   b;
            longint  cx, cy, r, a, hb;
            bit [23:0] dep;
            b = '{1'b0, 8'd0, 24'd0};
            case (c.mode)
                MODE_CLEAR: wipe();
                MODE_GRID: begin
                    for (int i = 0; i <= 10; i++)
                        for (int j = 0; j <= 10; j++)
                            if (project(longint'(-20 + 4 * i) * 4096, c.py,
                                        longint'(-20 + 4 * j) * 4096, cx, cy, dep))
                                plot(cx, cy, dep, CH_DOT);
                end
                MODE_SPHERE: begin
                    b.visible = project(c.px, c.py, c.pz, cx, cy, dep);
                    if (b.visible) begin
                        r = foot(c.sx, 60, dep);
                        for (longint dy = -(r / 2); dy <= r / 2; dy++) begin
                            if (cy + dy <= 0 || cy + dy >= H - 1) continue;
                            for (longint dx = -r; dx <= r; dx++)
                                if (dx * dx + dy * dy * 4 <= r * r + 1)
                                    plot(cx + dx, cy + dy, dep, c.glyph);
                        end
                    end
                end
                MODE_BOX: begin
                    b.visible = project(c.px, c.py, c.pz, cx, cy, dep);
                    if (b.visible) begin
                        a  = foot(c.sx, 70, dep);
                        hb = foot(c.sy, 35, dep);
                        for (longint dy = -hb; dy <= hb; dy++) begin
                            if (cy + dy <= 0 || cy + dy >= H - 1) continue;
                            for (longint dx = -a; dx <= a; dx++)
                                plot(cx + dx, cy + dy, dep, c.glyph);
                        end
                    end
                end
                MODE_READ: begin
                    if (c.cell_idx < CELLS) begin
                        b.glyph = glyph_mem[c.cell_idx];
                        b.depth = depth_mem[c.cell_idx];
                    end
                end
                default: ;
            endcase
            awaited = {awaited, b};
        endfunction

        function void check_beat(logic vis, logic [7:0] gl, logic [23:0] dp);
            beat_t e;
            if (awaited.size() == 0) begin
                $display("%0t: result beat with nothing pending: vis=%0b glyph=%0h depth=%0h",
                         $time, vis, gl, dp);
                errors++;
                return;
            end
            e = awaited.pop_front();
            if (vis !== e.visible) begin
                $display("%0t: visible expected %0b actual %0b", $time, e.visible, vis);
                errors++;
            end
            if (gl !== e.glyph) begin
                $display("%0t: glyph_out expected %0h actual %0h", $time, e.glyph, gl);
                errors++;
            end
            if (dp !== e.depth) begin
                $display("%0t: depth_out expected %0h actual %0h", $time, e.depth, dp);
                errors++;
            end
        endfunction

        function int pending();
            return awaited.size();
        endfunction
    endclass

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [2:0]         s_mode = MODE_READ;
    logic signed [23:0] s_pos_x = '0;
    logic signed [23:0] s_pos_y = '0;
    logic signed [23:0] s_pos_z = '0;
    logic [19:0]        s_size_x = '0;
    logic [19:0]        s_size_y = '0;
    logic [7:0]         s_glyph = '0;
    logic [11:0]        s_cell_index = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic               m_visible;
    logic [7:0]         m_glyph_out;
    logic [23:0]        m_depth_out;

    frame_shadow shadow = new();
    bit          calm = 1'b0;
    bit          hold_out = 1'b0;
    int          idle_cycles = 0;

    z_buffered_sprite_rasterizer_core u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_mode       (s_mode),
        .s_pos_x      (s_pos_x),
        .s_pos_y      (s_pos_y),
        .s_pos_z      (s_pos_z),
        .s_size_x     (s_size_x),
        .s_size_y     (s_size_y),
        .s_glyph      (s_glyph),
        .s_cell_index (s_cell_index),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_visible    (m_visible),
        .m_glyph_out  (m_glyph_out),
        .m_depth_out  (m_depth_out)
    );

    always #4 aclk = ~aclk;

    // beat monitor: results checked first, then the accepted command predicted
    always @(posedge aclk) begin
        cmd_t c;
        if (aresetn) begin
            if (m_valid && m_ready)
                shadow.check_beat(m_visible, m_glyph_out, m_depth_out);
            if (s_valid && s_ready) begin
                c.mode     = s_mode;
                c.px       = s_pos_x;
                c.py       = s_pos_y;
                c.pz       = s_pos_z;
                c.sx       = s_size_x;
                c.sy       = s_size_y;
                c.glyph    = s_glyph;
                c.cell_idx = s_cell_index;
                shadow.take_command(c);
            end
        end
    end

    // watchdog on cycles without any beat
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("[z_buffered_sprite_rasterizer_core] ERROR");
            $finish;
        end
    end

    // result side: random stall bursts, one long hold-off on request
    initial begin
        forever begin
            if (hold_out) begin
                m_ready <= 1'b0;
                repeat (400) @(posedge aclk);
                hold_out = 1'b0;
            end else if (calm || $urandom_range(0, 3) != 0) begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end else begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge aclk);
            end
        end
    end

    // offer one command and hold it until accepted
    task automatic push(cmd_t c);
        s_valid      <= 1'b1;
        s_mode       <= c.mode;
        s_pos_x      <= c.px;
        s_pos_y      <= c.py;
        s_pos_z      <= c.pz;
        s_size_x     <= c.sx;
        s_size_y     <= c.sy;
        s_glyph      <= c.glyph;
        s_cell_index <= c.cell_idx;
        do @(posedge aclk); while (!s_ready);
    endtask

    // occasional idle burst on the command side
    task automatic maybe_gap();
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
    endtask

    function automatic cmd_t mk(logic [2:0] m, int x, int y, int z, int sx, int sy,
                                int g, int cidx);
        cmd_t c;
        c.mode     = m;
        c.px       = 24'(x);
        c.py       = 24'(y);
        c.pz       = 24'(z);
        c.sx       = 20'(sx);
        c.sy       = 20'(sy);
        c.glyph    = 8'(g);
        c.cell_idx = 12'(cidx);
        return c;
    endfunction

    // world coordinate in whole units, scaled to Q12 with random fraction
    function automatic int world(int lo, int hi);
        return $urandom_range(0, hi - lo) * 4096 + lo * 4096 + $urandom_range(0, 4095);
    endfunction

    function automatic cmd_t random_cmd();
        cmd_t c;
        int   pick;
        pick = $urandom_range(0, 99);
        c = mk(MODE_READ, world(-15, 15), world(-4, 10), world(-6, 30),
               $urandom_range(0, 3 * 4096), $urandom_range(0, 3 * 4096),
               $urandom_range(0, 255), $urandom_range(0, CELLS - 1));
        if (pick < 38) begin
            c.mode = MODE_READ;
        end else if (pick < 64) begin
            c.mode = MODE_SPHERE;
        end else if (pick < 90) begin
            c.mode = MODE_BOX;
        end else if (pick < 92) begin
            c.mode = MODE_CLEAR;
        end else if (pick < 93) begin
            c.mode = MODE_GRID;
        end else begin
            // noise: raw fields over their whole range
            c.mode     = 3'($urandom_range(0, 7));
            c.px       = 24'($urandom);
            c.py       = 24'($urandom);
            c.pz       = 24'($urandom);
            c.sx       = 20'($urandom);
            c.sy       = 20'($urandom);
            c.cell_idx = 12'($urandom);
            if (c.mode == MODE_GRID) c.py = 24'(world(-4, 10));
        end
        return c;
    endfunction

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // directed opening
        push(mk(MODE_READ, 0, 0, 0, 0, 0, 0, 0));
        push(mk(MODE_READ, 0, 0, 0, 0, 0, 0, W - 1));
        push(mk(MODE_READ, 0, 0, 0, 0, 0, 0, CELLS - 1));
        push(mk(MODE_READ, 0, 0, 0, 0, 0, 0, W + 1));
        push(mk(MODE_READ, 0, 0, 0, 0, 0, 0, CELLS));
        push(mk(MODE_READ, 0, 0, 0, 0, 0, 0, 4095));
        push(mk(MODE_GRID, 0, 0, 0, 0, 0, 0, 0));
        push(mk(MODE_SPHERE, 0, 4 * 4096, 10 * 4096, 2 * 4096, 0, 8'h40, 0));
        push(mk(MODE_BOX, 3 * 4096, 2 * 4096, 8 * 4096, 4096, 4096, 8'h23, 0));
        push(mk(MODE_BOX, 3 * 4096, 2 * 4096, 20 * 4096, 4096, 4096, 8'hFF, 0));
        push(mk(MODE_SPHERE, 0, 12 * 4096, -22 * 4096, 4096, 0, 8'h2A, 0));
        push(mk(MODE_SPHERE, 0, 4 * 4096, 10 * 4096, 0, 0, 8'h00, 0));
        push(mk(MODE_BOX, 0, 4 * 4096, 40 * 4096, 20'hFFFFF, 20'hFFFFF, 8'h4F, 0));
        push(mk(MODE_SPHERE, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 20'hFFFFF, 0, 8'h31, 0));
        push(mk(MODE_BOX, -8388608, -8388608, -8388608, 4096, 4096, 8'h32, 0));
        push(mk(MODE_BOX, 0, 0, 24'h7FFFFF, 4096, 4096, 8'h33, 0));
        push(mk(3'd5, 0, 0, 0, 0, 0, 0, 0));
        push(mk(3'd6, 0, 0, 0, 0, 0, 0, 0));
        push(mk(3'd7, 0, 0, 0, 0, 0, 0, 0));
        push(mk(MODE_READ, 0, 0, 0, 0, 0, 0, 17 * W + 40));
        push(mk(MODE_CLEAR, 0, 0, 0, 0, 0, 0, 0));
        push(mk(MODE_READ, 0, 0, 0, 0, 0, 0, 17 * W + 40));

        // long output hold-off while reads keep arriving
        hold_out = 1'b1;
        for (int i = 0; i < 12; i++)
            push(mk(MODE_READ, 0, 0, 0, 0, 0, 0, $urandom_range(0, CELLS - 1)));

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == N_RANDOM / 2) begin
                // drain: wait for every pending result
                s_valid <= 1'b0;
                @(posedge aclk);
                while (shadow.pending() != 0) @(posedge aclk);
            end
            if (n == N_RANDOM - 200) calm = 1'b1;
            maybe_gap();
            push(random_cmd());
        end
        s_valid <= 1'b0;
        @(posedge aclk);

        while (shadow.pending() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (shadow.errors == 0 && shadow.pending() == 0)
            $display("[z_buffered_sprite_rasterizer_core] OK");
        else
            $display("[z_buffered_sprite_rasterizer_core] ERROR");
        $finish;
    end

endmodule
